// ----- hw/rtl/rwv_pkg.sv -----
// Shared constants and types for the rolling window variance block.
package rwv_pkg;

    // fixed field widths of the stream words and the config register
    localparam int CFG_W      = 7;
    localparam int IN_SAMPLE_W = 16;
    localparam int VAR_W      = 40;
    localparam int USED_W     = 7;
    localparam int OUT_DATA_W = 48;

    localparam logic [CFG_W-1:0] WIN_LEN_RESET = 7'd21;
    localparam logic [VAR_W-1:0] VAR_MAX       = {VAR_W{1'b1}};

    // back end sequencer states
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_WRITE = 7'b0000010,
        ST_ACC   = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_LOAD  = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_back_state;

endpackage

// ----- hw/rtl/rwv_front.sv -----
// Front end: accepts sample words, tracks series fill and slot, issues commands.
module rwv_front #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rwv_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rwv_pkg::IN_SAMPLE_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output logic [SAMPLE_BITS+$clog2(MAX_WINDOW)+$clog2(MAX_WINDOW+1):0] o_q_data
);
    import rwv_pkg::*;

    localparam int NW    = $clog2(MAX_WINDOW + 1);
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int RAW_W = (SAMPLE_BITS > IN_SAMPLE_W) ? SAMPLE_BITS : IN_SAMPLE_W;
    localparam int LW    = (NW > CFG_W) ? NW : CFG_W;

    logic [CFG_W-1:0] r_win_len;
    logic [NW-1:0]    r_fill;
    logic [AW-1:0]    r_slot;
    logic             r_seen;

    logic             accept;
    logic             first;
    logic [RAW_W-1:0] raw;
    logic [SAMPLE_BITS-1:0] x;
    logic [NW-1:0]    n_fill;
    logic [AW-1:0]    n_slot;
    logic [LW-1:0]    len_ext;
    logic [LW-1:0]    len_clamp;
    logic [NW-1:0]    len_n;
    logic [NW-1:0]    used;

    assign s_axis_tready = !i_q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_q_push      = accept;

    // take the low sample bits of the word
    assign raw = RAW_W'(s_axis_tdata);
    assign x   = raw[SAMPLE_BITS-1:0];

    assign first = s_axis_tuser || !r_seen;

    // count samples held in this series, saturating at the window depth
    always_comb begin
        if (first) begin
            n_fill = NW'(1);
        end else if (r_fill < NW'(MAX_WINDOW)) begin
            n_fill = r_fill + NW'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    // wrap the history slot at the window depth
    always_comb begin
        if (r_slot == AW'(MAX_WINDOW - 1)) begin
            n_slot = '0;
        end else begin
            n_slot = r_slot + AW'(1);
        end
    end

    // clamp the window length into 1..MAX_WINDOW
    always_comb begin
        len_ext = LW'(r_win_len);
        if (len_ext == '0) begin
            len_clamp = LW'(1);
        end else if (len_ext > LW'(MAX_WINDOW)) begin
            len_clamp = LW'(MAX_WINDOW);
        end else begin
            len_clamp = len_ext;
        end
        len_n = NW'(len_clamp);
        used  = (n_fill < len_n) ? n_fill : len_n;
    end

    // command fields, lowest first: sample, slot, count, first flag
    assign o_q_data = {first, used, r_slot, x};

    // hold config and series bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= WIN_LEN_RESET;
            r_fill    <= '0;
            r_slot    <= '0;
            r_seen    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win_len <= i_cfg_wdata;
            end
            if (accept) begin
                r_fill <= n_fill;
                r_slot <= n_slot;
                r_seen <= 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/rwv_queue.sv -----
// Two-entry command queue between the front and back ends.
module rwv_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // advance pointers and track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ----- hw/rtl/rwv_back.sv -----
// Back end: history memory, window sums, fixed point divide and result register.
module rwv_back #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    input  logic [SAMPLE_BITS+$clog2(MAX_WINDOW)+$clog2(MAX_WINDOW+1):0] i_q_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rwv_pkg::VAR_W-1:0]     o_variance,
    output logic [rwv_pkg::USED_W-1:0]    o_samples_used,
    output logic                          o_undefined
);
    import rwv_pkg::*;

    localparam int NW    = $clog2(MAX_WINDOW + 1);
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int SB    = SAMPLE_BITS;
    localparam int S1W   = SB + NW;
    localparam int SQW   = 2 * SB;
    localparam int S2W   = 2 * SB + NW;
    localparam int DW    = NW + S2W;
    localparam int DENW  = 2 * NW;
    localparam int NUMW  = DW + FRAC_BITS;
    localparam int CW    = $clog2(NUMW + 1);
    localparam int CMPW  = (NUMW > VAR_W + 1) ? NUMW : VAR_W + 1;

    t_back_state r_state;

    // latched command
    logic signed [SB-1:0] r_x;
    logic [AW-1:0]        r_slot;
    logic [NW-1:0]        r_n;
    logic                 r_first;

    // history memory and read pipeline
    logic signed [SB-1:0] r_hist [MAX_WINDOW];
    logic [AW-1:0]        r_rd_addr;
    logic [NW-1:0]        r_issue;
    logic                 rd_en;
    logic signed [SB-1:0] r_rd_data;
    logic                 r_rd_v;
    logic signed [SB-1:0] r_tap;
    logic [SQW-1:0]       r_sq;
    logic                 r_sq_v;
    logic signed [SQW-1:0] sq_full;

    // window sums
    logic signed [S1W-1:0] r_s1;
    logic [S2W-1:0]        r_s2;
    logic [S1W-1:0]        a1;

    // products and divider
    logic [DW-1:0]   r_ns2;
    logic [DW-1:0]   r_a1sq;
    logic [DENW-1:0] r_den;
    logic [NUMW-1:0] r_num;
    logic [DENW-1:0] r_rem;
    logic [CW-1:0]   r_div_cnt;
    logic [DENW:0]   trial;
    logic            q_bit;
    logic [DW-1:0]   diff;

    // result
    logic [CMPW-1:0]  q_ext;
    logic [VAR_W-1:0] res_var;
    logic             load_out;
    logic             r_ov;
    logic             acc_done;

    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;
    assign rd_en   = (r_state == ST_ACC) && (r_issue != '0);
    assign acc_done = (r_issue == '0) && !r_rd_v && !r_sq_v;
    assign load_out = (r_state == ST_DONE) && (!r_ov || i_ready);

    assign sq_full = r_rd_data * r_rd_data;
    assign a1      = (r_s1 < 0) ? S1W'(-r_s1) : S1W'(r_s1);
    assign diff    = r_ns2 - r_a1sq;

    assign trial = {r_rem, r_num[NUMW-1]};
    assign q_bit = (trial >= {1'b0, r_den});

    // saturate the quotient at the output range
    always_comb begin
        q_ext = CMPW'(r_num);
        if (q_ext > CMPW'(VAR_MAX)) begin
            res_var = VAR_MAX;
        end else begin
            res_var = VAR_W'(q_ext);
        end
    end

    // write the new sample, read the window back one slot a cycle
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            r_hist[r_slot] <= r_x;
        end
        if (rd_en) begin
            r_rd_data <= r_hist[r_rd_addr];
        end
    end

    // square stage
    always_ff @(posedge i_clk) begin
        r_sq  <= SQW'(sq_full);
        r_tap <= r_rd_data;
    end

    // sequencer, accumulators and divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_issue <= '0;
            r_rd_v  <= 1'b0;
            r_sq_v  <= 1'b0;
        end else begin
            r_rd_v <= rd_en;
            r_sq_v <= r_rd_v;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        {r_first, r_n, r_slot, r_x} <= i_q_data;
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_rd_addr <= r_slot;
                    r_issue   <= r_n;
                    r_s1      <= '0;
                    r_s2      <= '0;
                    r_state   <= (r_n == NW'(1)) ? ST_DONE : ST_ACC;
                end
                ST_ACC: begin
                    if (rd_en) begin
                        r_issue <= r_issue - NW'(1);
                        if (r_rd_addr == '0) begin
                            r_rd_addr <= AW'(MAX_WINDOW - 1);
                        end else begin
                            r_rd_addr <= r_rd_addr - AW'(1);
                        end
                    end
                    if (r_sq_v) begin
                        r_s1 <= r_s1 + S1W'(r_tap);
                        r_s2 <= r_s2 + S2W'(r_sq);
                    end
                    if (acc_done) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_ns2   <= DW'(r_n * r_s2);
                    r_a1sq  <= DW'(a1 * a1);
                    r_den   <= DENW'(r_n * (r_n - NW'(1)));
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_num     <= NUMW'(diff) << FRAC_BITS;
                    r_rem     <= '0;
                    r_div_cnt <= CW'(NUMW);
                    r_state   <= ST_DIV;
                end
                ST_DIV: begin
                    // one quotient bit a cycle, restoring
                    if (q_bit) begin
                        r_rem <= DENW'(trial - {1'b0, r_den});
                    end else begin
                        r_rem <= DENW'(trial);
                    end
                    r_num     <= {r_num[NUMW-2:0], q_bit};
                    r_div_cnt <= r_div_cnt - CW'(1);
                    if (r_div_cnt == CW'(1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // hold the result word until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_out) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_samples_used <= USED_W'(r_n);
            if (r_n == NW'(1)) begin
                o_variance  <= '0;
                o_undefined <= !r_first;
            end else begin
                o_variance  <= res_var;
                o_undefined <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;

endmodule

// ----- hw/rtl/rolling_window_variance.sv -----
// Top level of the moving window sample variance block.
// A single-sample window skips readback and divide; larger windows read the history back,
// then divide with a quotient of NUMW = 2*clog2(MAX_WINDOW+1) + 2*SAMPLE_BITS + FRAC_BITS
// bits (54 by default). The back end handles one word at a time; the two-entry queue
// lets the front end accept more words meanwhile. The window readback (one history slot
// a cycle) and the restoring divider (one quotient bit a cycle) set the pace.
// Reset (synchronous, active low) clears series state; window length returns to 21.
module rolling_window_variance #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rwv_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] sample
    input  logic [rwv_pkg::IN_SAMPLE_W-1:0]   s_axis_tdata,
    // [0] series_start
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [39:0] variance, [46:40] samples_used, [47] zero
    output logic [rwv_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] undefined
    output logic                              m_axis_tuser
);
    import rwv_pkg::*;

    localparam int QDW = SAMPLE_BITS + $clog2(MAX_WINDOW) + $clog2(MAX_WINDOW + 1) + 1;

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    logic [QDW-1:0]   push_data;
    logic [QDW-1:0]   pop_data;
    logic [VAR_W-1:0] variance;
    logic [USED_W-1:0] samples_used;

    rwv_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .o_q_push      (push),
        .o_q_data      (push_data)
    );

    rwv_queue #(
        .WIDTH (QDW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (pop_data)
    );

    rwv_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .o_q_pop        (pop),
        .i_q_data       (pop_data),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_variance     (variance),
        .o_samples_used (samples_used),
        .o_undefined    (m_axis_tuser)
    );

    // pack the result word, lowest field first
    assign m_axis_tdata = {1'b0, samples_used, variance};

endmodule
